>>> hdl/vnd_pkg.sv
// Shared widths, mode codes and pipeline word types for the vertex normal direction block.
package vnd_pkg;

    localparam int VEC_W      = 36;   // signed difference vectors
    localparam int MAG_W      = 35;   // component magnitudes
    localparam int ROOT_W     = 31;   // normalized magnitudes and quotients
    localparam int SQ_W       = 64;   // sum of squares and root working width
    localparam int N_W        = 32;   // vector norm
    localparam int REM_W      = 33;   // division remainder
    localparam int DIR_W      = 32;   // Q2.30 output component
    localparam int Q_FRAC     = 30;
    localparam int NORM_STEPS = 6;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    // Magnitude, square, sum, divider setup and output registers plus the cell chains.
    localparam int UNIT_LAT   = NORM_STEPS + SQRT_STEPS + DIV_STEPS + 5;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_ORTHO  = 2'd0;
    localparam t_mode MODE_MEDIAN = 2'd1;
    localparam t_mode MODE_ANGLE  = 2'd2;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic             sx;
        logic             sy;
    } t_norm_word;

    typedef struct packed {
        logic [SQ_W-1:0]   v;
        logic [SQ_W-1:0]   res;
        logic [ROOT_W-1:0] ux;
        logic [ROOT_W-1:0] uy;
        logic              sx;
        logic              sy;
        logic              zero;
    } t_sqrt_word;

    typedef struct packed {
        logic [REM_W-1:0]  rem_x;
        logic [REM_W-1:0]  rem_y;
        logic [ROOT_W-1:0] lo_x;
        logic [ROOT_W-1:0] lo_y;
        logic [ROOT_W-1:0] q_x;
        logic [ROOT_W-1:0] q_y;
        logic [N_W-1:0]    n;
        logic              sx;
        logic              sy;
        logic              zero;
    } t_div_word;

endpackage

>>> hdl/vnd_norm_cell.sv
// One cell of the normalizing shifter: shifts both magnitudes left when the top bits are clear.
module vnd_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  vnd_pkg::t_norm_word   i_word,
    output vnd_pkg::t_norm_word   o_word
);

    logic [vnd_pkg::MAG_W-1:0] w_or;
    vnd_pkg::t_norm_word       n_word;
    vnd_pkg::t_norm_word       r_word;

    assign w_or = i_word.mx | i_word.my;

    always_comb begin
        n_word = i_word;
        if (w_or[vnd_pkg::MAG_W-1 -: SHIFT] == '0) begin
            n_word.mx = i_word.mx << SHIFT;
            n_word.my = i_word.my << SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> hdl/vnd_sqrt_cell.sv
// One cell of the square root chain: settles one result bit of the integer root.
module vnd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  vnd_pkg::t_sqrt_word   i_word,
    output vnd_pkg::t_sqrt_word   o_word
);

    localparam logic [vnd_pkg::SQ_W-1:0] BIT_VAL =
        vnd_pkg::SQ_W'(1) << (vnd_pkg::SQ_W - 2 - 2 * STEP);

    logic [vnd_pkg::SQ_W-1:0] w_trial;
    vnd_pkg::t_sqrt_word      n_word;
    vnd_pkg::t_sqrt_word      r_word;

    assign w_trial = i_word.res + BIT_VAL;

    always_comb begin
        n_word = i_word;
        if (i_word.v >= w_trial) begin
            n_word.v   = i_word.v - w_trial;
            n_word.res = (i_word.res >> 1) + BIT_VAL;
        end else begin
            n_word.res = i_word.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> hdl/vnd_div_cell.sv
// One cell of the restoring divider: one quotient bit for each of the two components.
module vnd_div_cell (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  vnd_pkg::t_div_word   i_word,
    output vnd_pkg::t_div_word   o_word
);

    logic [vnd_pkg::REM_W-1:0] w_rx;
    logic [vnd_pkg::REM_W-1:0] w_ry;
    logic [vnd_pkg::REM_W-1:0] w_n;
    vnd_pkg::t_div_word        n_word;
    vnd_pkg::t_div_word        r_word;

    // The remainder stays below the norm, so its top bit is always clear before the shift.
    assign w_rx = {i_word.rem_x[vnd_pkg::REM_W-2:0], i_word.lo_x[vnd_pkg::ROOT_W-1]};
    assign w_ry = {i_word.rem_y[vnd_pkg::REM_W-2:0], i_word.lo_y[vnd_pkg::ROOT_W-1]};
    assign w_n  = {1'b0, i_word.n};

    always_comb begin
        n_word      = i_word;
        n_word.lo_x = i_word.lo_x << 1;
        n_word.lo_y = i_word.lo_y << 1;
        if (w_rx >= w_n) begin
            n_word.rem_x = w_rx - w_n;
            n_word.q_x   = {i_word.q_x[vnd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_word.rem_x = w_rx;
            n_word.q_x   = {i_word.q_x[vnd_pkg::ROOT_W-2:0], 1'b0};
        end
        if (w_ry >= w_n) begin
            n_word.rem_y = w_ry - w_n;
            n_word.q_y   = {i_word.q_y[vnd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_word.rem_y = w_ry;
            n_word.q_y   = {i_word.q_y[vnd_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> hdl/vnd_unit.sv
// Pipelined vector normalizer: shift, square, root and divide chains giving a Q2.30 unit vector.
module vnd_unit (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [vnd_pkg::VEC_W-1:0]   i_x,
    input  logic signed [vnd_pkg::VEC_W-1:0]   i_y,
    output logic signed [vnd_pkg::DIR_W-1:0]   o_x,
    output logic signed [vnd_pkg::DIR_W-1:0]   o_y,
    output logic                               o_ok
);

    localparam int NUM_W = vnd_pkg::ROOT_W + vnd_pkg::Q_FRAC + 1;

    logic [vnd_pkg::VEC_W-1:0]      w_ax;
    logic [vnd_pkg::VEC_W-1:0]      w_ay;
    vnd_pkg::t_norm_word            r_mag;
    vnd_pkg::t_norm_word            w_norm [vnd_pkg::NORM_STEPS+1];
    logic [vnd_pkg::ROOT_W-1:0]     w_ux;
    logic [vnd_pkg::ROOT_W-1:0]     w_uy;
    logic [2*vnd_pkg::ROOT_W-1:0]   w_sqx;
    logic [2*vnd_pkg::ROOT_W-1:0]   w_sqy;
    logic [2*vnd_pkg::ROOT_W-1:0]   r_sqx;
    logic [2*vnd_pkg::ROOT_W-1:0]   r_sqy;
    logic [vnd_pkg::ROOT_W-1:0]     r_ux;
    logic [vnd_pkg::ROOT_W-1:0]     r_uy;
    logic                           r_sx;
    logic                           r_sy;
    logic                           r_zero;
    vnd_pkg::t_sqrt_word            r_sum;
    vnd_pkg::t_sqrt_word            w_sqrt [vnd_pkg::SQRT_STEPS+1];
    logic [vnd_pkg::N_W-1:0]        w_n;
    logic [NUM_W-1:0]               w_num_x;
    logic [NUM_W-1:0]               w_num_y;
    vnd_pkg::t_div_word             r_dinit;
    vnd_pkg::t_div_word             w_div [vnd_pkg::DIV_STEPS+1];
    vnd_pkg::t_div_word             w_last;
    logic signed [vnd_pkg::DIR_W-1:0] w_qx;
    logic signed [vnd_pkg::DIR_W-1:0] w_qy;
    logic signed [vnd_pkg::DIR_W-1:0] r_x;
    logic signed [vnd_pkg::DIR_W-1:0] r_y;
    logic                             r_ok;

    assign w_ax = i_x[vnd_pkg::VEC_W-1] ? -i_x : i_x;
    assign w_ay = i_y[vnd_pkg::VEC_W-1] ? -i_y : i_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag.mx <= w_ax[vnd_pkg::MAG_W-1:0];
            r_mag.my <= w_ay[vnd_pkg::MAG_W-1:0];
            r_mag.sx <= i_x[vnd_pkg::VEC_W-1];
            r_mag.sy <= i_y[vnd_pkg::VEC_W-1];
        end
    end

    // Left-normalize until the larger magnitude reaches the top bit; the top 31 bits then hold
    // both magnitudes scaled alike, the larger into [2^30, 2^31), with truncation.
    assign w_norm[0] = r_mag;
    for (genvar k = 0; k < vnd_pkg::NORM_STEPS; k++) begin : g_norm
        vnd_norm_cell #(
            .SHIFT (1 << (vnd_pkg::NORM_STEPS - 1 - k))
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_word (w_norm[k]),
            .o_word (w_norm[k+1])
        );
    end

    assign w_ux  = w_norm[vnd_pkg::NORM_STEPS].mx[vnd_pkg::MAG_W-1 -: vnd_pkg::ROOT_W];
    assign w_uy  = w_norm[vnd_pkg::NORM_STEPS].my[vnd_pkg::MAG_W-1 -: vnd_pkg::ROOT_W];
    assign w_sqx = w_ux * w_ux;
    assign w_sqy = w_uy * w_uy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx  <= w_sqx;
            r_sqy  <= w_sqy;
            r_ux   <= w_ux;
            r_uy   <= w_uy;
            r_sx   <= w_norm[vnd_pkg::NORM_STEPS].sx;
            r_sy   <= w_norm[vnd_pkg::NORM_STEPS].sy;
            r_zero <= (w_norm[vnd_pkg::NORM_STEPS].mx | w_norm[vnd_pkg::NORM_STEPS].my) == '0;
            r_sum.v    <= vnd_pkg::SQ_W'(r_sqx) + vnd_pkg::SQ_W'(r_sqy);
            r_sum.res  <= '0;
            r_sum.ux   <= r_ux;
            r_sum.uy   <= r_uy;
            r_sum.sx   <= r_sx;
            r_sum.sy   <= r_sy;
            r_sum.zero <= r_zero;
        end
    end

    assign w_sqrt[0] = r_sum;
    for (genvar k = 0; k < vnd_pkg::SQRT_STEPS; k++) begin : g_sqrt
        vnd_sqrt_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_word (w_sqrt[k]),
            .o_word (w_sqrt[k+1])
        );
    end

    // Rounded quotient: (u * 2^30 + n / 2) / n. The top bits of the numerator start the
    // remainder, since the quotient fits in 31 bits.
    assign w_n     = w_sqrt[vnd_pkg::SQRT_STEPS].res[vnd_pkg::N_W-1:0];
    assign w_num_x = NUM_W'({w_sqrt[vnd_pkg::SQRT_STEPS].ux, vnd_pkg::Q_FRAC'(0)})
                     + NUM_W'(w_n[vnd_pkg::N_W-1:1]);
    assign w_num_y = NUM_W'({w_sqrt[vnd_pkg::SQRT_STEPS].uy, vnd_pkg::Q_FRAC'(0)})
                     + NUM_W'(w_n[vnd_pkg::N_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dinit.rem_x <= vnd_pkg::REM_W'(w_num_x[NUM_W-1 -: vnd_pkg::ROOT_W]);
            r_dinit.rem_y <= vnd_pkg::REM_W'(w_num_y[NUM_W-1 -: vnd_pkg::ROOT_W]);
            r_dinit.lo_x  <= w_num_x[vnd_pkg::ROOT_W-1:0];
            r_dinit.lo_y  <= w_num_y[vnd_pkg::ROOT_W-1:0];
            r_dinit.q_x   <= '0;
            r_dinit.q_y   <= '0;
            r_dinit.n     <= w_n;
            r_dinit.sx    <= w_sqrt[vnd_pkg::SQRT_STEPS].sx;
            r_dinit.sy    <= w_sqrt[vnd_pkg::SQRT_STEPS].sy;
            r_dinit.zero  <= w_sqrt[vnd_pkg::SQRT_STEPS].zero;
        end
    end

    assign w_div[0] = r_dinit;
    for (genvar k = 0; k < vnd_pkg::DIV_STEPS; k++) begin : g_div
        vnd_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_word (w_div[k]),
            .o_word (w_div[k+1])
        );
    end

    assign w_last = w_div[vnd_pkg::DIV_STEPS];
    assign w_qx   = vnd_pkg::DIR_W'(w_last.q_x);
    assign w_qy   = vnd_pkg::DIR_W'(w_last.q_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_last.zero) begin
                r_x <= '0;
                r_y <= '0;
            end else begin
                r_x <= w_last.sx ? -w_qx : w_qx;
                r_y <= w_last.sy ? -w_qy : w_qy;
            end
            r_ok <= !w_last.zero;
        end
    end

    assign o_x  = r_x;
    assign o_y  = r_y;
    assign o_ok = r_ok;

endmodule

>>> hdl/vertex_normal_direction_core.sv
// Top level: unit direction vector at a polyline vertex, fully pipelined.
//
// Input channel: i_in_valid / o_in_stall carry one word of three vertices (next, previous,
// current) in signed fixed point. Output channel: o_out_valid / i_out_stall carry one word
// of o_dir_x, o_dir_y (signed Q2.30) and o_degenerate. A word moves at a clock edge where
// valid is high and stall is low.
// i_cfg_wr_en writes i_cfg_wr_data into the mode register: 0 orthogonal, 1 median,
// 2 median of unit edges; the value 3 acts as orthogonal. Write it only while idle.
// Throughput is one word per cycle while the output is not stalled. A word accepted at a
// clock edge passes through an input register, two normalizer units in series (each of
// 6 shift cells, 32 root cells, 31 divider cells and five registers), one register between
// them and three for mode select, the flip test and the output, where its result appears.
// The whole pipeline advances together. While the output register holds a word and the
// receiver stalls, the pipeline freezes and o_in_stall is raised; otherwise a word is
// accepted every cycle. Reset clears the mode to orthogonal and empties the pipeline.
module vertex_normal_direction_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_next_x,
    input  logic signed [COORD_WIDTH-1:0] i_next_y,
    input  logic signed [COORD_WIDTH-1:0] i_prev_x,
    input  logic signed [COORD_WIDTH-1:0] i_prev_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_dir_x,
    output logic signed [31:0]            o_dir_y,
    output logic                          o_degenerate
);

    localparam int DROP = (COORD_WIDTH > 32) ? COORD_WIDTH - 32 : 0;
    localparam int KEEP = COORD_WIDTH - DROP;
    localparam int TOT  = 2 * vnd_pkg::UNIT_LAT + 5;
    localparam int DW   = vnd_pkg::DIR_W;
    localparam int VW   = vnd_pkg::VEC_W;

    typedef struct packed {
        logic signed [DW-1:0] ox;
        logic signed [DW-1:0] oy;
        logic                 ok0;
        logic signed [DW-1:0] d1x;
        logic signed [DW-1:0] d1y;
        logic                 ok1;
        logic                 okab;
    } t_dly;

    logic                   w_adv;
    vnd_pkg::t_mode         r_mode;
    logic [TOT-1:0]         r_vld;
    logic [COORD_WIDTH-1:0] w_fld [6];
    logic signed [VW-1:0]   w_crd [6];
    logic signed [VW-1:0]   w_eax, w_eay, w_ebx, w_eby;
    logic signed [VW-1:0]   r_ox_in, r_oy_in, r_v1x, r_v1y, r_v2x, r_v2y;
    logic signed [DW-1:0]   w_u0x, w_u0y, w_u1x, w_u1y, w_u2x, w_u2y, w_u3x, w_u3y;
    logic                   w_ok0, w_ok1, w_ok2, w_ok3;
    logic signed [VW-1:0]   r_sax, r_say;
    t_dly                   r_dl [vnd_pkg::UNIT_LAT+1];
    t_dly                   w_dl_out;
    logic signed [DW-1:0]   r_f1_dx, r_f1_dy, r_f1_ox, r_f1_oy;
    logic                   r_f1_ok;
    logic signed [DW-1:0]   r_f2_dx, r_f2_dy;
    logic                   r_f2_ok;
    logic signed [63:0]     w_px, w_py, w_dot;
    logic signed [63:0]     r_px, r_py;
    logic                   w_flip;
    logic signed [DW-1:0]   r_out_x, r_out_y;
    logic                   r_out_deg;

    assign w_adv      = !(r_vld[TOT-1] && i_out_stall);
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= vnd_pkg::MODE_ORTHO;
            r_vld  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (w_adv) begin
                r_vld <= {r_vld[TOT-2:0], i_in_valid};
            end
        end
    end

    assign w_fld[0] = i_next_x;
    assign w_fld[1] = i_next_y;
    assign w_fld[2] = i_prev_x;
    assign w_fld[3] = i_prev_y;
    assign w_fld[4] = i_center_x;
    assign w_fld[5] = i_center_y;

    // Wide coordinates keep only their top 32 bits.
    for (genvar g = 0; g < 6; g++) begin : g_crd
        logic signed [KEEP-1:0] w_k;
        assign w_k      = w_fld[g][COORD_WIDTH-1:DROP];
        assign w_crd[g] = VW'(w_k);
    end

    assign w_eax = w_crd[0] - w_crd[4];
    assign w_eay = w_crd[1] - w_crd[5];
    assign w_ebx = w_crd[2] - w_crd[4];
    assign w_eby = w_crd[3] - w_crd[5];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ox_in <= w_crd[3] - w_crd[1];
            r_oy_in <= w_crd[0] - w_crd[2];
            r_v1x   <= (r_mode == vnd_pkg::MODE_MEDIAN) ? w_eax + w_ebx : w_eax;
            r_v1y   <= (r_mode == vnd_pkg::MODE_MEDIAN) ? w_eay + w_eby : w_eay;
            r_v2x   <= w_ebx;
            r_v2y   <= w_eby;
        end
    end

    vnd_unit u_unit_ortho (
        .i_clk (i_clk), .i_en (w_adv), .i_x (r_ox_in), .i_y (r_oy_in),
        .o_x (w_u0x), .o_y (w_u0y), .o_ok (w_ok0)
    );

    vnd_unit u_unit_first (
        .i_clk (i_clk), .i_en (w_adv), .i_x (r_v1x), .i_y (r_v1y),
        .o_x (w_u1x), .o_y (w_u1y), .o_ok (w_ok1)
    );

    vnd_unit u_unit_edge (
        .i_clk (i_clk), .i_en (w_adv), .i_x (r_v2x), .i_y (r_v2y),
        .o_x (w_u2x), .o_y (w_u2y), .o_ok (w_ok2)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sax         <= VW'(w_u1x) + VW'(w_u2x);
            r_say         <= VW'(w_u1y) + VW'(w_u2y);
            r_dl[0].ox    <= w_u0x;
            r_dl[0].oy    <= w_u0y;
            r_dl[0].ok0   <= w_ok0;
            r_dl[0].d1x   <= w_u1x;
            r_dl[0].d1y   <= w_u1y;
            r_dl[0].ok1   <= w_ok1;
            r_dl[0].okab  <= w_ok1 && w_ok2;
            for (int k = 1; k <= vnd_pkg::UNIT_LAT; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    vnd_unit u_unit_sum (
        .i_clk (i_clk), .i_en (w_adv), .i_x (r_sax), .i_y (r_say),
        .o_x (w_u3x), .o_y (w_u3y), .o_ok (w_ok3)
    );

    assign w_dl_out = r_dl[vnd_pkg::UNIT_LAT];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_ox <= w_dl_out.ox;
            r_f1_oy <= w_dl_out.oy;
            case (r_mode)
                vnd_pkg::MODE_MEDIAN: begin
                    r_f1_dx <= w_dl_out.d1x;
                    r_f1_dy <= w_dl_out.d1y;
                    r_f1_ok <= w_dl_out.ok1;
                end
                vnd_pkg::MODE_ANGLE: begin
                    r_f1_dx <= w_u3x;
                    r_f1_dy <= w_u3y;
                    r_f1_ok <= w_dl_out.okab && w_ok3;
                end
                default: begin
                    r_f1_dx <= w_dl_out.ox;
                    r_f1_dy <= w_dl_out.oy;
                    r_f1_ok <= w_dl_out.ok0;
                end
            endcase
        end
    end

    assign w_px = r_f1_ox * r_f1_dx;
    assign w_py = r_f1_oy * r_f1_dy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px    <= w_px;
            r_py    <= w_py;
            r_f2_dx <= r_f1_dx;
            r_f2_dy <= r_f1_dy;
            r_f2_ok <= r_f1_ok;
        end
    end

    // Median and unit-edge median results point to the side of the orthogonal normal.
    assign w_dot  = r_px + r_py;
    assign w_flip = r_f2_ok && w_dot[63]
                    && (r_mode == vnd_pkg::MODE_MEDIAN || r_mode == vnd_pkg::MODE_ANGLE);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (!r_f2_ok) begin
                r_out_x <= '0;
                r_out_y <= '0;
            end else if (w_flip) begin
                r_out_x <= -r_f2_dx;
                r_out_y <= -r_f2_dy;
            end else begin
                r_out_x <= r_f2_dx;
                r_out_y <= r_f2_dy;
            end
            r_out_deg <= !r_f2_ok;
        end
    end

    assign o_out_valid  = r_vld[TOT-1];
    assign o_dir_x      = r_out_x;
    assign o_dir_y      = r_out_y;
    assign o_degenerate = r_out_deg;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> o_dir_x == 0 && o_dir_y == 0)
        else $error("degenerate word with nonzero direction");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_degenerate |->
            o_dir_x <= 32'sh4000_0000 && o_dir_x >= -32'sh4000_0000
            && o_dir_y <= 32'sh4000_0000 && o_dir_y >= -32'sh4000_0000)
        else $error("direction component beyond one");

    a_nonzero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_degenerate |-> o_dir_x != 0 || o_dir_y != 0)
        else $error("valid direction is the zero vector");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");

endmodule
